// File: hdl/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and codes of the per-sender in-order resequencer.
// ----------------------------------------------------------------------------
package psr_pkg;

	localparam int SENDER_W = 16;
	localparam int SEQ_W    = 31;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BUFFERED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SNDR  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STALE     = 3'd4;

	// output queue geometry
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PW    = 2;

	// classified input word, front to back
	typedef struct packed {
		logic                bad;
		logic [SENDER_W-1:0] sender;
		logic [SEQ_W-1:0]    seq;
		logic [SEQ_W-1:0]    handle;
	} item_t;

	// result word, back to output queue
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SENDER_W-1:0] sender;
		logic [SEQ_W-1:0]    seq;
		logic [SEQ_W-1:0]    handle;
		logic                last;
	} result_t;

	// back end to output queue
	typedef struct packed {
		logic    push;
		result_t data;
	} oq_wr_t;

endpackage

// File: hdl/psr_ram.sv
// ----------------------------------------------------------------------------
// psr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module psr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the read word while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/psr_front.sv
// ----------------------------------------------------------------------------
// psr_front
// Accepts input words, flags bad senders and holds them in a two-word queue.
// ----------------------------------------------------------------------------
module psr_front import psr_pkg::*; #(
	parameter int MAX_SENDERS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [SENDER_W-1:0] sender,
	input  logic [SEQ_W-1:0]    seq,
	input  logic [SEQ_W-1:0]    msg_handle,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                take,
	output logic                avail,
	output item_t               item
);

	localparam logic [SENDER_W:0] MAX_X = (SENDER_W+1)'(MAX_SENDERS);

	logic [CFG_W-1:0]    active_q;
	item_t               ent_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;
	logic [SENDER_W:0]   act_x;
	logic [SENDER_W:0]   limit;
	logic                acc;
	item_t               in_item;

	assign act_x = (SENDER_W+1)'(active_q);
	assign limit = (act_x < MAX_X) ? act_x : MAX_X;
	assign acc   = push && !full;
	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign item  = ent_q[rd_ptr_q];

	always_comb begin
		in_item.bad    = ({1'b0, sender} >= limit);
		in_item.sender = sender;
		in_item.seq    = seq;
		in_item.handle = msg_handle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CFG_W'(16);
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (acc) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(acc) - 2'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// File: hdl/psr_back.sv
// ----------------------------------------------------------------------------
// psr_back
// Looks up sender state, stores out-of-order words and walks the release
// chain, one released word per cycle while the output queue is not full.
// ----------------------------------------------------------------------------
module psr_back import psr_pkg::*; #(
	parameter int MAX_SENDERS = 16,
	parameter int WINDOW      = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   avail,
	input  item_t  item,
	output logic   take,
	input  logic   oq_full,
	output oq_wr_t oq_wr
);

	localparam int SW     = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
	localparam int HW     = $clog2(WINDOW);
	localparam int STW    = SEQ_W + WINDOW + HW;
	localparam int HDEPTH = 1 << (SW + HW);
	localparam logic [HW:0]       WIN_X   = (HW+1)'(WINDOW);
	localparam logic [HW-1:0]     HEAD_MX = HW'(WINDOW - 1);
	localparam logic [SEQ_W-1:0]  WIN_SEQ = SEQ_W'(WINDOW);
	localparam logic [WINDOW-1:0] ONE_W   = {{(WINDOW-1){1'b0}}, 1'b1};

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CHK   = 3'b010,
		S_DRAIN = 3'b100
	} back_state_t;

	back_state_t         state_q, state_d;
	item_t               cur_s1;
	logic [MAX_SENDERS-1:0] sv_q;
	logic [SEQ_W-1:0]    w_exp_q, w_exp_d;
	logic [WINDOW-1:0]   w_valid_q, w_valid_d;
	logic [HW-1:0]       w_head_q, w_head_d;
	logic                load_w;

	logic [SW-1:0]       idx;
	logic                st_we, st_re, h_we, h_re;
	logic [STW-1:0]      st_rdata, st_wdata;
	logic [SW+HW-1:0]    h_waddr, h_raddr;
	logic [SEQ_W-1:0]    h_rdata;

	logic [SEQ_W-1:0]    cur_exp;
	logic [WINDOW-1:0]   cur_valid;
	logic [HW-1:0]       cur_head;
	logic [SEQ_W-1:0]    d;
	logic                in_win;
	logic [HW:0]         sum;
	logic [HW-1:0]       slot;
	logic [WINDOW-1:0]   set_valid;
	logic [HW-1:0]       c_head_nx;
	logic [WINDOW-1:0]   c_valid_nx;
	logic                c_more;
	logic [SEQ_W-1:0]    c_exp_nx;
	logic [WINDOW-1:0]   w_valid_clr;
	logic [HW-1:0]       w_head_nx;
	logic                w_more;
	logic [SEQ_W-1:0]    w_exp_nx;

	assign idx = cur_s1.sender[SW-1:0];

	psr_ram #(
		.WIDTH(STW),
		.DEPTH(MAX_SENDERS)
	) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (idx),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (item.sender[SW-1:0]),
		.rdata (st_rdata)
	);

	psr_ram #(
		.WIDTH(SEQ_W),
		.DEPTH(HDEPTH)
	) u_h_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (cur_s1.handle),
		.re    (h_re),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// a sender never written reads as all zero
	always_comb begin
		if (sv_q[idx]) begin
			cur_exp   = st_rdata[STW-1 -: SEQ_W];
			cur_valid = st_rdata[HW +: WINDOW];
			cur_head  = st_rdata[HW-1:0];
		end else begin
			cur_exp   = '0;
			cur_valid = '0;
			cur_head  = '0;
		end
	end

	assign d         = cur_s1.seq - cur_exp;
	assign in_win    = (d < WIN_SEQ);
	assign sum       = {1'b0, cur_head} + {1'b0, d[HW-1:0]};
	assign slot      = (sum >= WIN_X) ? HW'(sum - WIN_X) : sum[HW-1:0];
	assign set_valid = cur_valid | (ONE_W << slot);
	assign c_head_nx = (cur_head == HEAD_MX) ? '0 : cur_head + 1'b1;
	assign c_valid_nx = cur_valid & ~(ONE_W << cur_head);
	assign c_more    = c_valid_nx[c_head_nx];
	assign c_exp_nx  = cur_exp + 1'b1;

	assign w_valid_clr = w_valid_q & ~(ONE_W << w_head_q);
	assign w_head_nx   = (w_head_q == HEAD_MX) ? '0 : w_head_q + 1'b1;
	assign w_more      = w_valid_clr[w_head_nx];
	assign w_exp_nx    = w_exp_q + 1'b1;

	assign h_waddr = {idx, slot};

	always_comb begin
		state_d   = state_q;
		take      = 1'b0;
		st_re     = 1'b0;
		st_we     = 1'b0;
		st_wdata  = '0;
		h_we      = 1'b0;
		h_re      = 1'b0;
		h_raddr   = {idx, c_head_nx};
		load_w    = 1'b0;
		w_exp_d   = c_exp_nx;
		w_valid_d = c_valid_nx;
		w_head_d  = c_head_nx;
		oq_wr.push        = 1'b0;
		oq_wr.data.status = ST_DELIVERED;
		oq_wr.data.sender = cur_s1.sender;
		oq_wr.data.seq    = cur_s1.seq;
		oq_wr.data.handle = cur_s1.handle;
		oq_wr.data.last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (avail) begin
					take    = 1'b1;
					st_re   = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (!oq_full) begin
					oq_wr.push = 1'b1;
					state_d    = S_IDLE;
					if (cur_s1.bad) begin
						oq_wr.data.status = ST_BAD_SNDR;
					end else if (!in_win) begin
						oq_wr.data.status = d[SEQ_W-1] ? ST_STALE : ST_BEYOND;
					end else if (d != '0) begin
						oq_wr.data.status = ST_BUFFERED;
						h_we     = 1'b1;
						st_we    = 1'b1;
						st_wdata = {cur_exp, set_valid, cur_head};
					end else begin
						// the arriving word is the expected one: release it at once
						oq_wr.data.last = !c_more;
						if (c_more) begin
							h_re    = 1'b1;
							load_w  = 1'b1;
							state_d = S_DRAIN;
						end else begin
							st_we    = 1'b1;
							st_wdata = {c_exp_nx, c_valid_nx, c_head_nx};
						end
					end
				end
			end
			S_DRAIN: begin
				h_raddr = {idx, w_head_nx};
				if (!oq_full) begin
					oq_wr.push        = 1'b1;
					oq_wr.data.seq    = w_exp_q;
					oq_wr.data.handle = h_rdata;
					oq_wr.data.last   = !w_more;
					load_w    = 1'b1;
					w_exp_d   = w_exp_nx;
					w_valid_d = w_valid_clr;
					w_head_d  = w_head_nx;
					if (w_more) begin
						h_re = 1'b1;
					end else begin
						st_we    = 1'b1;
						st_wdata = {w_exp_nx, w_valid_clr, w_head_nx};
						state_d  = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sv_q    <= '0;
		end else begin
			state_q <= state_d;
			if (st_we) begin
				sv_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_s1 <= item;
		end
		if (load_w) begin
			w_exp_q   <= w_exp_d;
			w_valid_q <= w_valid_d;
			w_head_q  <= w_head_d;
		end
	end

endmodule

// File: hdl/psr_outq.sv
// ----------------------------------------------------------------------------
// psr_outq
// Small result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module psr_outq import psr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  oq_wr_t  oq_wr,
	output logic    oq_full,
	output logic    empty,
	input  logic    pop,
	output result_t dout
);

	result_t         ent_q [OQ_DEPTH];
	logic [OQ_PW-1:0] wr_ptr_q;
	logic [OQ_PW-1:0] rd_ptr_q;
	logic [OQ_PW:0]   cnt_q;
	logic             wr;
	logic             rd;

	assign oq_full = (cnt_q == (OQ_PW+1)'(OQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign wr      = oq_wr.push && !oq_full;
	assign rd      = pop && !empty;
	assign dout    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (OQ_PW+1)'(wr) - (OQ_PW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wr_ptr_q] <= oq_wr.data;
		end
	end

endmodule

// File: hdl/per_sender_inorder_resequencer.sv
// ----------------------------------------------------------------------------
// per_sender_inorder_resequencer
// Releases each sender's messages in sequence order, buffering early ones.
// ----------------------------------------------------------------------------
// channel   direction  handshake         word
// input     in         push / full       sender, seq, msg_handle
// result    out        empty / pop       status, out_sender, out_seq, out_handle, last
// config    in         cfg_we            cfg_wdata (active_senders)
//
// In the back end an item has its sender state read, then is classified and
// stored; each further message that it releases is walked out by the drain,
// which is bound by the single read port of the handle RAM.
// A two-word input queue and a four-word result queue decouple both sides.
// Reset clears all sender state through per-sender valid flops; no sweep.
// ----------------------------------------------------------------------------
module per_sender_inorder_resequencer import psr_pkg::*; #(
	parameter int MAX_SENDERS = 16,
	parameter int WINDOW      = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [SENDER_W-1:0] sender,
	input  logic [SEQ_W-1:0]    seq,
	input  logic [SEQ_W-1:0]    msg_handle,
	output logic                empty,
	input  logic                pop,
	output logic [STATUS_W-1:0] status,
	output logic [SENDER_W-1:0] out_sender,
	output logic [SEQ_W-1:0]    out_seq,
	output logic [SEQ_W-1:0]    out_handle,
	output logic                last,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata
);

	item_t   item;
	logic    avail;
	logic    take;
	logic    oq_full;
	oq_wr_t  oq_wr;
	result_t dout;

	psr_front #(
		.MAX_SENDERS(MAX_SENDERS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sender     (sender),
		.seq        (seq),
		.msg_handle (msg_handle),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.take       (take),
		.avail      (avail),
		.item       (item)
	);

	psr_back #(
		.MAX_SENDERS(MAX_SENDERS),
		.WINDOW     (WINDOW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.avail   (avail),
		.item    (item),
		.take    (take),
		.oq_full (oq_full),
		.oq_wr   (oq_wr)
	);

	psr_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.oq_wr   (oq_wr),
		.oq_full (oq_full),
		.empty   (empty),
		.pop     (pop),
		.dout    (dout)
	);

	assign status     = dout.status;
	assign out_sender = dout.sender;
	assign out_seq    = dout.seq;
	assign out_handle = dout.handle;
	assign last       = dout.last;

endmodule
